// ----- rtl/dmcrc16_pkg.sv -----
// Package for the dual-mode frame CRC-16 block: register indexes, CRC constants
// and the byte-wide CRC update functions.
// No dependencies.
package dmcrc16_pkg;

  // Configuration register indexes.
  localparam logic CFG_PROTOCOL_MODE = 1'b0;
  localparam logic CFG_CHECK_MODE    = 1'b1;

  // CRC constants.
  localparam logic [15:0] POLY_REFLECTED = 16'hA001;
  localparam logic [15:0] POLY_CCITT     = 16'h1021;
  localparam logic [15:0] INIT_REFLECTED = 16'hFFFF;
  localparam logic [15:0] INIT_CCITT     = 16'h0000;
  localparam logic [15:0] MSB_MASK       = 16'h8000;
  localparam logic [15:0] LSB_MASK       = 16'h0001;

  // Reflected CRC update of one byte, LSB first.
  function automatic logic [15:0] upd_reflected(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if ((x & LSB_MASK) != 16'h0000) begin
        x = (x >> 1) ^ POLY_REFLECTED;
      end else begin
        x = x >> 1;
      end
    end
    return x;
  endfunction

  // CCITT CRC update of one byte, MSB first.
  function automatic logic [15:0] upd_ccitt(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((x & MSB_MASK) != 16'h0000) begin
        x = (x << 1) ^ POLY_CCITT;
      end else begin
        x = x << 1;
      end
    end
    return x;
  endfunction

endpackage

// ----- rtl/dual_mode_frame_crc16.sv -----
// Top level of the dual-mode frame CRC-16 block: byte stream in, one CRC result
// per frame out. Depends on dmcrc16_pkg.
//
// Usage:
//   The slave stream carries one frame byte per transaction in s_axis_tdata, with
//   s_axis_tlast on the final byte of the frame. On that final byte one result
//   transaction leaves on the master stream: the CRC word in m_axis_tdata[15:0]
//   and the match flag in m_axis_tdata[16]. Other bytes produce no result.
//   Protocol mode 0 is the reflected CRC (0xA001, init 0xFFFF); mode 1 is CCITT
//   0x1021 over byte pairs, second byte first, with a byte-swapped result.
//   In check mode the final two bytes of a frame pass through a two-byte delay
//   and are compared with the CRC of the bytes before them.
//   The byte-wide CRC update (two updates for a CCITT pair) sits between the input
//   port and the CRC and result registers, so a byte is accepted every cycle and
//   a result appears in the cycle after its last byte. The single result register
//   limits the rate only while it is full and not taken: s_axis_tready is then
//   low until the receiver takes the result.
//   Reset clears both mode registers and the result and restarts the frame state.
//   A configuration write restarts the frame state with the new mode.
module dual_mode_frame_crc16 (
  input  logic        clk,
  input  logic        rst,
  // Input byte stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] crc_word, [16] crc_match, [23:17] zero
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);

  // Mode registers.
  logic protocol_mode;
  logic check_mode;

  // Frame state.
  logic [15:0] crc_register;
  logic [7:0]  pair_hold_byte;
  logic        pair_phase;
  logic [7:0]  tail_delay0;
  logic [7:0]  tail_delay1;
  logic [1:0]  byte_count;

  // Result register.
  logic [15:0] crc_word;
  logic        crc_match;

  logic s_fire;
  logic m_fire;

  // Combinational byte update.
  logic        feed_en;
  logic [7:0]  feed_byte;
  logic [15:0] crc_next;
  logic [7:0]  pair_hold_byte_next;
  logic        pair_phase_next;
  logic [15:0] final_word;
  logic [15:0] recv_word;
  logic        match_next;
  logic [1:0]  byte_count_next;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {7'b0000000, crc_match, crc_word};

  // Feed the byte into the CRC, either directly or through the tail delay.
  always_comb begin
    feed_en             = !check_mode || (byte_count >= 2'd2);
    feed_byte           = check_mode ? tail_delay0 : s_axis_tdata;
    crc_next            = crc_register;
    pair_hold_byte_next = pair_hold_byte;
    pair_phase_next     = pair_phase;
    if (feed_en) begin
      if (!protocol_mode) begin
        crc_next = dmcrc16_pkg::upd_reflected(crc_register, feed_byte);
      end else if (!pair_phase) begin
        pair_hold_byte_next = feed_byte;
        pair_phase_next     = 1'b1;
      end else begin
        crc_next = dmcrc16_pkg::upd_ccitt(
                     dmcrc16_pkg::upd_ccitt(crc_register, feed_byte), pair_hold_byte);
        pair_phase_next = 1'b0;
      end
    end
    final_word      = protocol_mode ? {crc_next[7:0], crc_next[15:8]} : crc_next;
    recv_word       = {s_axis_tdata, tail_delay1};
    match_next      = check_mode && (byte_count >= 2'd2) && (recv_word == final_word);
    byte_count_next = (byte_count == 2'd3) ? byte_count : byte_count + 2'd1;
  end

  // Mode registers and frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_mode  <= 1'b0;
      check_mode     <= 1'b0;
      crc_register   <= dmcrc16_pkg::INIT_REFLECTED;
      pair_hold_byte <= 8'h00;
      pair_phase     <= 1'b0;
      tail_delay0    <= 8'h00;
      tail_delay1    <= 8'h00;
      byte_count     <= 2'd0;
    end else if (cfg_we) begin
      // A write restarts the frame with the initial value of the new mode.
      case (cfg_index)
        dmcrc16_pkg::CFG_PROTOCOL_MODE: begin
          protocol_mode <= cfg_data;
          crc_register  <= cfg_data ? dmcrc16_pkg::INIT_CCITT : dmcrc16_pkg::INIT_REFLECTED;
        end
        dmcrc16_pkg::CFG_CHECK_MODE: begin
          check_mode   <= cfg_data;
          crc_register <= protocol_mode ? dmcrc16_pkg::INIT_CCITT
                                        : dmcrc16_pkg::INIT_REFLECTED;
        end
        default: begin
          crc_register <= crc_register;
        end
      endcase
      pair_hold_byte <= 8'h00;
      pair_phase     <= 1'b0;
      tail_delay0    <= 8'h00;
      tail_delay1    <= 8'h00;
      byte_count     <= 2'd0;
    end else if (s_fire) begin
      if (s_axis_tlast) begin
        crc_register   <= protocol_mode ? dmcrc16_pkg::INIT_CCITT
                                        : dmcrc16_pkg::INIT_REFLECTED;
        pair_hold_byte <= 8'h00;
        pair_phase     <= 1'b0;
        tail_delay0    <= 8'h00;
        tail_delay1    <= 8'h00;
        byte_count     <= 2'd0;
      end else begin
        crc_register   <= crc_next;
        pair_hold_byte <= pair_hold_byte_next;
        pair_phase     <= pair_phase_next;
        tail_delay0    <= check_mode ? tail_delay1 : tail_delay0;
        tail_delay1    <= check_mode ? s_axis_tdata : tail_delay1;
        byte_count     <= byte_count_next;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_fire && s_axis_tlast) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_fire) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Result payload, loaded on the last byte of a frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_word  <= 16'h0000;
      crc_match <= 1'b0;
    end else if (s_fire && s_axis_tlast) begin
      crc_word  <= final_word;
      crc_match <= match_next;
    end
  end

  // A last byte always leaves a result waiting in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_axis_tlast) |=> m_axis_tvalid)
    else $error("last byte accepted without a result");

  // A byte that is not the last never creates a result.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    (s_fire && !s_axis_tlast && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result raised by a non-last byte");

  // Frame state is back at its start after a frame ends.
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_axis_tlast) |=> (byte_count == 2'd0 && !pair_phase))
    else $error("frame state not cleared after last byte");

  // The pair phase is only used by the CCITT mode.
  a_pair_phase_mode: assert property (@(posedge clk) disable iff (rst)
    !protocol_mode |-> !pair_phase)
    else $error("pair phase set in reflected mode");

endmodule
